FILE: rtl/core/dcld_pkg.sv
// shared types and codes for the two-channel led slew dimmer
// no dependencies; used by dcld_ramp, dcld_out and the core top level
package dcld_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int TMODE_BITS     = 3;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ENABLE      = 3'd0,
        REG_TMODE       = 3'd1,
        REG_POLARITY    = 3'd2,
        REG_SWAP        = 3'd3,
        REG_SMOOTH_STEP = 3'd4
    } cfg_reg_t;

    // test-mode goal selection, codes above TM_BOTH act as normal
    typedef enum logic [TMODE_BITS-1:0] {
        TM_NORMAL = 3'd0,
        TM_OFF    = 3'd1,
        TM_WARM   = 3'd2,
        TM_COOL   = 3'd3,
        TM_BOTH   = 3'd4
    } tmode_t;

    // output-side control bits handed to the result stage
    typedef struct packed {
        logic enable;
        logic pol_high;
        logic swap_channels;
    } out_ctrl_t;

endpackage

FILE: rtl/core/dcld_if.sv
// request and result channel interfaces for the dimmer
// no dependencies; level width and duty width set per instance
interface dcld_req_if #(
    parameter int LW = 17
);
    logic          valid;
    logic          ready;
    logic          mode;
    logic [LW-1:0] warm_req;
    logic [LW-1:0] cool_req;

    modport source (output valid, mode, warm_req, cool_req, input ready);
    modport sink (input valid, mode, warm_req, cool_req, output ready);
endinterface

interface dcld_rsp_if #(
    parameter int LW = 17,
    parameter int DB = 13
);
    logic          valid;
    logic          ready;
    logic [DB-1:0] channel0_duty;
    logic [DB-1:0] channel1_duty;
    logic [LW-1:0] warm_now;
    logic [LW-1:0] cool_now;
    logic          active;

    modport source (output valid, channel0_duty, channel1_duty, warm_now, cool_now,
                    active, input ready);
    modport sink (input valid, channel0_duty, channel1_duty, warm_now, cool_now,
                  active, output ready);
endinterface

FILE: rtl/core/dcld_ramp.sv
// goal storage and per-request slew of the warm and cool levels
// depends on dcld_pkg for the test-mode codes
module dcld_ramp #(
    parameter int LEVEL_FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic                     mode,
    input  logic [LEVEL_FRAC_BITS:0] warm_req,
    input  logic [LEVEL_FRAC_BITS:0] cool_req,
    input  logic                     clear,
    input  logic                     enable,
    input  logic [dcld_pkg::TMODE_BITS-1:0] tmode,
    input  logic [LEVEL_FRAC_BITS:0] smooth_step,
    output logic [LEVEL_FRAC_BITS:0] warm_level,
    output logic [LEVEL_FRAC_BITS:0] cool_level
);
    localparam int LW = LEVEL_FRAC_BITS + 1;
    localparam longint unsigned FULL_L = 64'd1 << LEVEL_FRAC_BITS;
    localparam logic [LW-1:0] FULL = LW'(FULL_L);
    localparam logic [LW-1:0] GOAL_015 = LW'((FULL_L * 64'd15 + 64'd50) / 64'd100);
    localparam logic [LW-1:0] GOAL_010 = LW'((FULL_L * 64'd10 + 64'd50) / 64'd100);

    logic [LW-1:0] warm_level_reg, warm_level_next;
    logic [LW-1:0] cool_level_reg, cool_level_next;
    logic [LW-1:0] warm_goal_reg, warm_goal_next;
    logic [LW-1:0] cool_goal_reg, cool_goal_next;
    logic [LW-1:0] warm_eff, cool_eff;

    function automatic logic [LW-1:0] sat_full(input logic [LW-1:0] v);
        sat_full = (v > FULL) ? FULL : v;
    endfunction

    function automatic logic [LW-1:0] slew(input logic [LW-1:0] now,
                                           input logic [LW-1:0] goal,
                                           input logic [LW-1:0] step);
        logic [LW:0]   up;
        logic [LW-1:0] diff;
        logic [LW-1:0] res;
        up   = {1'b0, now} + {1'b0, step};
        diff = now - goal;
        if (now < goal)
        begin
            res = (up > {1'b0, goal}) ? goal : up[LW-1:0];
        end
        else if (now > goal)
        begin
            res = (diff > step) ? (now - step) : goal;
        end
        else
        begin
            res = now;
        end
        slew = sat_full(res);
    endfunction

    always_comb
    begin
        case (tmode)
            dcld_pkg::TM_OFF:
            begin
                warm_eff = '0;
                cool_eff = '0;
            end
            dcld_pkg::TM_WARM:
            begin
                warm_eff = GOAL_015;
                cool_eff = '0;
            end
            dcld_pkg::TM_COOL:
            begin
                warm_eff = '0;
                cool_eff = GOAL_015;
            end
            dcld_pkg::TM_BOTH:
            begin
                warm_eff = GOAL_010;
                cool_eff = GOAL_010;
            end
            default:
            begin
                warm_eff = warm_goal_reg;
                cool_eff = cool_goal_reg;
            end
        endcase
    end

    always_comb
    begin
        warm_level_next = warm_level_reg;
        cool_level_next = cool_level_reg;
        warm_goal_next  = warm_goal_reg;
        cool_goal_next  = cool_goal_reg;
        if (clear)
        begin
            warm_level_next = '0;
            cool_level_next = '0;
            warm_goal_next  = '0;
            cool_goal_next  = '0;
        end
        else if (accept)
        begin
            if (mode)
            begin
                warm_goal_next = sat_full(warm_req);
                cool_goal_next = sat_full(cool_req);
            end
            else if (!enable)
            begin
                warm_level_next = '0;
                cool_level_next = '0;
            end
            else
            begin
                warm_level_next = slew(warm_level_reg, warm_eff, smooth_step);
                cool_level_next = slew(cool_level_reg, cool_eff, smooth_step);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_level_reg <= '0;
            cool_level_reg <= '0;
            warm_goal_reg  <= '0;
            cool_goal_reg  <= '0;
        end
        else
        begin
            warm_level_reg <= warm_level_next;
            cool_level_reg <= cool_level_next;
            warm_goal_reg  <= warm_goal_next;
            cool_goal_reg  <= cool_goal_next;
        end
    end

    assign warm_level = warm_level_reg;
    assign cool_level = cool_level_reg;

endmodule

FILE: rtl/core/dcld_duty.sv
// level to pwm duty mapping: round(level * dmax / full) with polarity
// no dependencies; pure combinational, one instance per channel
module dcld_duty #(
    parameter int LEVEL_FRAC_BITS = 16,
    parameter int DUTY_BITS       = 13
) (
    input  logic [LEVEL_FRAC_BITS:0] level,
    input  logic                     enable,
    input  logic                     pol_high,
    output logic [DUTY_BITS-1:0]     duty
);
    localparam int LW = LEVEL_FRAC_BITS + 1;
    localparam int PW = LW + DUTY_BITS;
    localparam logic [LW-1:0] FULL = LW'(64'd1 << LEVEL_FRAC_BITS);
    localparam logic [PW-1:0] HALF = PW'(64'd1 << (LEVEL_FRAC_BITS - 1));
    localparam logic [DUTY_BITS-1:0] DMAX = '1;

    logic [LW-1:0]        lvl;
    logic [PW-1:0]        prod;
    logic [PW-1:0]        rounded;
    logic [DUTY_BITS:0]   d_raw;
    logic [DUTY_BITS-1:0] d;

    always_comb
    begin
        if (!enable)
        begin
            lvl = '0;
        end
        else
        begin
            lvl = (level > FULL) ? FULL : level;
        end
        // times dmax as a shift and subtract
        prod    = {lvl, {DUTY_BITS{1'b0}}} - PW'(lvl);
        rounded = prod + HALF;
        d_raw   = rounded[PW-1:LEVEL_FRAC_BITS];
        d       = (d_raw > {1'b0, DMAX}) ? DMAX : d_raw[DUTY_BITS-1:0];
        duty    = pol_high ? d : (DMAX - d);
    end

endmodule

FILE: rtl/core/dcld_out.sv
// result register: duty mapping, channel swap and output handshake
// depends on dcld_pkg, dcld_if and dcld_duty
module dcld_out #(
    parameter int LEVEL_FRAC_BITS = 16,
    parameter int DUTY_BITS       = 13
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     stage_valid,
    input  logic [LEVEL_FRAC_BITS:0] warm_level,
    input  logic [LEVEL_FRAC_BITS:0] cool_level,
    input  dcld_pkg::out_ctrl_t      ctrl,
    output logic                     take,
    dcld_rsp_if.source               result
);
    localparam int LW = LEVEL_FRAC_BITS + 1;

    logic                 valid_reg, valid_next;
    logic [DUTY_BITS-1:0] ch0_reg, ch1_reg;
    logic [LW-1:0]        warm_reg, cool_reg;
    logic                 active_reg;
    logic [DUTY_BITS-1:0] warm_duty, cool_duty;

    dcld_duty #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
        .DUTY_BITS       (DUTY_BITS)
    ) u_warm_duty (
        .level    (warm_level),
        .enable   (ctrl.enable),
        .pol_high (ctrl.pol_high),
        .duty     (warm_duty)
    );

    dcld_duty #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
        .DUTY_BITS       (DUTY_BITS)
    ) u_cool_duty (
        .level    (cool_level),
        .enable   (ctrl.enable),
        .pol_high (ctrl.pol_high),
        .duty     (cool_duty)
    );

    assign take = stage_valid && (!valid_reg || result.ready);

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ch0_reg    <= ctrl.swap_channels ? cool_duty : warm_duty;
            ch1_reg    <= ctrl.swap_channels ? warm_duty : cool_duty;
            warm_reg   <= warm_level;
            cool_reg   <= cool_level;
            active_reg <= ctrl.enable;
        end
    end

    assign result.valid         = valid_reg;
    assign result.channel0_duty = ch0_reg;
    assign result.channel1_duty = ch1_reg;
    assign result.warm_now      = warm_reg;
    assign result.cool_now      = cool_reg;
    assign result.active        = active_reg;

endmodule

FILE: rtl/core/dual_channel_led_slew_dimmer_core.sv
// top level of the two-channel slew-limited led dimmer: config registers and pipeline control
// depends on dcld_pkg, dcld_if, dcld_ramp and dcld_out
//
//  channel   dir  payload                                              handshake
//  request   in   mode, warm_req, cool_req                             valid / ready
//  result    out  channel0_duty, channel1_duty, warm_now, cool_now,    valid / ready
//                 active
//  cfg       in   cfg_index, cfg_data                                  cfg_we, no wait
//
// one request per cycle while the result is not stalled; a request passes the level registers, then the result register
// stage one is the level registers (slew), stage two the result register (duty map)
// a stalled result holds stage one; a new request is still taken when stage one moves on
// reset gives enable and high polarity set, step about 1% of full, levels and goals zero
module dual_channel_led_slew_dimmer_core #(
    parameter int LEVEL_FRAC_BITS = 16,
    parameter int DUTY_BITS       = 13
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dcld_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [LEVEL_FRAC_BITS:0]            cfg_data,
    dcld_req_if.sink                            request,
    dcld_rsp_if.source                          result
);
    localparam int LW = LEVEL_FRAC_BITS + 1;
    localparam logic [LW-1:0] STEP_RESET =
        LW'(((64'd1 << LEVEL_FRAC_BITS) + 64'd50) / 64'd100);

    logic                            enable_reg, enable_next;
    logic [dcld_pkg::TMODE_BITS-1:0] tmode_reg, tmode_next;
    logic                            pol_high_reg, pol_high_next;
    logic                            swap_reg, swap_next;
    logic [LW-1:0]                   step_reg, step_next;
    logic                            clear;

    logic                stage_valid_reg, stage_valid_next;
    logic                accept;
    logic                take;
    logic [LW-1:0]       warm_level, cool_level;
    dcld_pkg::out_ctrl_t ctrl;

    always_comb
    begin
        enable_next   = enable_reg;
        tmode_next    = tmode_reg;
        pol_high_next = pol_high_reg;
        swap_next     = swap_reg;
        step_next     = step_reg;
        clear         = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                dcld_pkg::REG_ENABLE:
                begin
                    enable_next = cfg_data[0];
                    clear       = !cfg_data[0];
                end
                dcld_pkg::REG_TMODE:       tmode_next    = cfg_data[dcld_pkg::TMODE_BITS-1:0];
                dcld_pkg::REG_POLARITY:    pol_high_next = cfg_data[0];
                dcld_pkg::REG_SWAP:        swap_next     = cfg_data[0];
                dcld_pkg::REG_SMOOTH_STEP: step_next     = cfg_data;
                default:                   clear         = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b1;
            tmode_reg    <= dcld_pkg::TM_NORMAL;
            pol_high_reg <= 1'b1;
            swap_reg     <= 1'b0;
            step_reg     <= STEP_RESET;
        end
        else
        begin
            enable_reg   <= enable_next;
            tmode_reg    <= tmode_next;
            pol_high_reg <= pol_high_next;
            swap_reg     <= swap_next;
            step_reg     <= step_next;
        end
    end

    // stage one holds the request whose levels sit in the ramp registers
    assign request.ready = !stage_valid_reg || take;
    assign accept        = request.valid && request.ready;

    always_comb
    begin
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (take)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    dcld_ramp #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_ramp (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (request.mode),
        .warm_req    (request.warm_req),
        .cool_req    (request.cool_req),
        .clear       (clear),
        .enable      (enable_reg),
        .tmode       (tmode_reg),
        .smooth_step (step_reg),
        .warm_level  (warm_level),
        .cool_level  (cool_level)
    );

    assign ctrl.enable        = enable_reg;
    assign ctrl.pol_high      = pol_high_reg;
    assign ctrl.swap_channels = swap_reg;

    dcld_out #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
        .DUTY_BITS       (DUTY_BITS)
    ) u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid_reg),
        .warm_level  (warm_level),
        .cool_level  (cool_level),
        .ctrl        (ctrl),
        .take        (take),
        .result      (result)
    );

endmodule
